// ===== rtl/core/dra_pkg.sv =====
package dra_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AddrW   = 32;

  localparam logic [StatusW-1:0] StatusOk   = 2'd0;
  localparam logic [StatusW-1:0] StatusBad  = 2'd1;
  localparam logic [StatusW-1:0] StatusNone = 2'd2;

  localparam logic [ByteW-1:0] PtrMask  = 8'hC0;
  localparam logic [ByteW-1:0] MaxLabel = 8'd63;
  localparam logic [3:0]       FixedLen = 4'd10;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   address;
  } dra_result_t;

endpackage

// ===== rtl/core/dns_response_a_record_extractor.sv =====
// Parses a DNS response streamed one byte per beat and reports the first A
// record (type 1, length 4) as status plus IPv4 address, one result per packet,
// issued for the beat that carries last_byte_i. Bytes are taken at one per
// cycle with no gaps required unless the input stalls; the last byte passes
// the input register and the parser before the result register offers the
// result. The input register feeds the parser, whose state advances once per
// byte, and the result register holds the outcome. Input stalls only when a
// last byte is in the input register while downstream stalls an untaken result.
module dns_response_a_record_extractor import dra_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [AddrW-1:0]   address_o
);

  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;
  logic             out_free;
  logic             s1_go;
  logic             s1_load;
  dra_result_t      res;
  logic             o_valid_q;
  dra_result_t      o_res_q;

  assign out_free   = !o_valid_q || !out_stall_i;
  assign s1_go      = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  dra_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_go),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (out_free) begin
      o_valid_q <= s1_go && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_go && s1_last_q) o_res_q <= res;
  end

  assign out_valid_o = o_valid_q;
  assign status_o    = o_res_q.status;
  assign address_o   = o_res_q.address;

endmodule

// ===== rtl/core/dra_parse.sv =====
module dra_parse import dra_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [ByteW-1:0]  byte_i,
  input  logic              last_i,
  output dra_result_t       result_o
);

  localparam logic [3:0] PhHeader = 4'd0;
  localparam logic [3:0] PhQLen   = 4'd1;
  localparam logic [3:0] PhQLabel = 4'd2;
  localparam logic [3:0] PhQTail  = 4'd3;
  localparam logic [3:0] PhQEnd   = 4'd4;
  localparam logic [3:0] PhAName  = 4'd5;
  localparam logic [3:0] PhAPtr   = 4'd6;
  localparam logic [3:0] PhALen   = 4'd7;
  localparam logic [3:0] PhALabel = 4'd8;
  localparam logic [3:0] PhAFixed = 4'd9;
  localparam logic [3:0] PhAData  = 4'd10;
  localparam logic [3:0] PhAddr   = 4'd11;
  localparam logic [3:0] PhDone   = 4'd12;

  logic [3:0]         ph_q, ph_d;
  logic [3:0]         pos_q, pos_d;
  logic [15:0]        ans_q, ans_d;
  logic [15:0]        skip_q, skip_d;
  logic [15:0]        rtype_q, rtype_d;
  logic [15:0]        rlen_q, rlen_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [StatusW-1:0] verdict_q, verdict_d;
  logic               fixed_q, fixed_d;

  logic [15:0] skip_dec;
  logic [15:0] ans_dec;
  logic [15:0] rlen_full;
  logic [3:0]  pos_inc;
  logic        is_ptr;

  assign skip_dec  = skip_q - 16'd1;
  assign ans_dec   = ans_q - 16'd1;
  assign rlen_full = {rlen_q[15:8], byte_i};
  assign pos_inc   = pos_q + 4'd1;
  assign is_ptr    = (byte_i & PtrMask) == PtrMask;

  always_comb begin
    ph_d      = ph_q;
    pos_d     = pos_q;
    ans_d     = ans_q;
    skip_d    = skip_q;
    rtype_d   = rtype_q;
    rlen_d    = rlen_q;
    addr_d    = addr_q;
    verdict_d = verdict_q;
    fixed_d   = fixed_q;
    if (!fixed_q) begin
      unique case (ph_q) inside
        PhHeader: begin
          if (pos_q == 4'd6) ans_d = {byte_i, 8'd0};
          if (pos_q == 4'd7) ans_d = {ans_q[15:8], byte_i};
          if (pos_q == 4'd11) begin
            pos_d = 4'd0;
            if (ans_q == 16'd0) begin
              verdict_d = StatusNone;
              fixed_d   = 1'b1;
              ph_d      = PhDone;
            end else begin
              ph_d = PhQLen;
            end
          end else begin
            pos_d = pos_inc;
          end
        end
        PhQLen: begin
          if (byte_i == '0) begin
            skip_d = 16'd4;
            ph_d   = PhQTail;
          end else if (byte_i > MaxLabel) begin
            verdict_d = StatusBad;
            fixed_d   = 1'b1;
            ph_d      = PhDone;
          end else begin
            skip_d = {8'd0, byte_i};
            ph_d   = PhQLabel;
          end
        end
        PhQLabel: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) ph_d = PhQLen;
        end
        PhQTail: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) ph_d = PhQEnd;
        end
        PhQEnd, PhAName: begin
          pos_d = 4'd0;
          if (is_ptr) begin
            ph_d = PhAPtr;
          end else if (byte_i == '0) begin
            ph_d = PhAFixed;
          end else begin
            skip_d = {8'd0, byte_i};
            ph_d   = PhALabel;
          end
        end
        PhAPtr: ph_d = PhAFixed;
        PhALen: begin
          if (byte_i == '0) begin
            ph_d = PhAFixed;
          end else begin
            skip_d = {8'd0, byte_i};
            ph_d   = PhALabel;
          end
        end
        PhALabel: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) ph_d = PhALen;
        end
        PhAFixed: begin
          if (pos_q == 4'd0) rtype_d = {byte_i, 8'd0};
          if (pos_q == 4'd1) rtype_d = {rtype_q[15:8], byte_i};
          if (pos_q == 4'd8) rlen_d = {byte_i, 8'd0};
          if (pos_q == FixedLen - 4'd1) begin
            rlen_d = rlen_full;
            pos_d  = 4'd0;
            if (rtype_q == 16'd1 && rlen_full == 16'd4) begin
              addr_d = '0;
              ph_d   = PhAddr;
            end else begin
              ans_d  = ans_dec;
              skip_d = rlen_full;
              if (ans_dec == 16'd0) begin
                verdict_d = StatusNone;
                fixed_d   = 1'b1;
                ph_d      = PhDone;
              end else if (rlen_full == 16'd0) begin
                ph_d = PhAName;
              end else begin
                ph_d = PhAData;
              end
            end
          end else begin
            pos_d = pos_inc;
          end
        end
        PhAData: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) ph_d = PhAName;
        end
        PhAddr: begin
          addr_d = {addr_q[AddrW-ByteW-1:0], byte_i};
          if (pos_q == 4'd3) begin
            verdict_d = StatusOk;
            fixed_d   = 1'b1;
            ph_d      = PhDone;
          end else begin
            pos_d = pos_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // outcome as seen after this beat has been taken
  always_comb begin
    if (fixed_d) result_o.status = verdict_d;
    else if (ph_d == PhAName || ph_d == PhAData) result_o.status = StatusNone;
    else result_o.status = StatusBad;
    result_o.address = (result_o.status == StatusOk) ? addr_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PhHeader;
      pos_q     <= '0;
      ans_q     <= '0;
      skip_q    <= '0;
      rtype_q   <= '0;
      rlen_q    <= '0;
      addr_q    <= '0;
      verdict_q <= '0;
      fixed_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        ph_q      <= PhHeader;
        pos_q     <= '0;
        ans_q     <= '0;
        skip_q    <= '0;
        rtype_q   <= '0;
        rlen_q    <= '0;
        addr_q    <= '0;
        verdict_q <= '0;
        fixed_q   <= 1'b0;
      end else begin
        ph_q      <= ph_d;
        pos_q     <= pos_d;
        ans_q     <= ans_d;
        skip_q    <= skip_d;
        rtype_q   <= rtype_d;
        rlen_q    <= rlen_d;
        addr_q    <= addr_d;
        verdict_q <= verdict_d;
        fixed_q   <= fixed_d;
      end
    end
  end

endmodule

// ===== rtl/core/dra_checker.sv =====
module dra_checker import dra_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [StatusW-1:0] status_o,
  input logic [AddrW-1:0]   address_o
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == StatusOk || status_o == StatusBad ||
                     status_o == StatusNone))
    else $error("status code out of range");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> address_o == '0)
    else $error("address not zero on a failed lookup");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(address_o))
    else $error("stalled result beat changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without downstream back-pressure");

endmodule

bind dns_response_a_record_extractor dra_checker u_dra_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o),
  .address_o  (address_o)
);
